// ===== rtl/core/gfec_pkg.sv =====
`default_nettype none

package gfec_pkg;

  localparam int unsigned MaxDataBlocks   = 16;
  localparam int unsigned MaxParityBlocks = 4;

  localparam int unsigned SymW    = 4;
  localparam int unsigned DataW   = 2 * SymW;
  localparam int unsigned IdxW    = $clog2(MaxDataBlocks);
  localparam int unsigned CoeffW  = MaxDataBlocks * SymW;
  localparam int unsigned KW      = 5;
  localparam int unsigned MW      = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = CoeffW;
  localparam int unsigned GfOrder = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoeff0       = 3'd0,
    CfgCoeff1       = 3'd1,
    CfgCoeff2       = 3'd2,
    CfgCoeff3       = 3'd3,
    CfgDataBlocks   = 3'd4,
    CfgParityBlocks = 3'd5
  } cfg_reg_e;

  localparam logic [SymW-1:0] GfLog [GfOrder] = '{
    4'd0, 4'd1, 4'd4, 4'd2, 4'd8, 4'd5, 4'd10, 4'd3,
    4'd14, 4'd9, 4'd7, 4'd6, 4'd13, 4'd11, 4'd12
  };

  localparam logic [SymW-1:0] GfExp [GfOrder] = '{
    4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd6, 4'd12, 4'd11,
    4'd5, 4'd10, 4'd7, 4'd14, 4'd15, 4'd13, 4'd9
  };

  function automatic logic [SymW-1:0] gf16_mul(input logic [SymW-1:0] a,
                                               input logic [SymW-1:0] b);
    logic [SymW:0] s;
    logic [SymW-1:0] r;
    r = '0;
    if (a != '0 && b != '0) begin
      s = {1'b0, GfLog[SymW'(a - 1'b1)]} + {1'b0, GfLog[SymW'(b - 1'b1)]};
      if (s >= (SymW+1)'(GfOrder)) begin
        s = s - (SymW+1)'(GfOrder);
      end
      r = GfExp[s[SymW-1:0]];
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] gf16_mul_byte(input logic [DataW-1:0] d,
                                                     input logic [SymW-1:0] c);
    return {gf16_mul(d[DataW-1:SymW], c), gf16_mul(d[SymW-1:0], c)};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gfec_if.sv =====
`default_nettype none

interface gfec_in_if import gfec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic [IdxW-1:0]  block_index;

  modport source (output valid, output data_byte, output block_index, input ready);
  modport sink   (input valid, input data_byte, input block_index, output ready);
endinterface

interface gfec_out_if import gfec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] parity_byte0;
  logic [DataW-1:0] parity_byte1;
  logic [DataW-1:0] parity_byte2;
  logic [DataW-1:0] parity_byte3;
  logic             bad_index;

  modport source (output valid, output parity_byte0, output parity_byte1,
                  output parity_byte2, output parity_byte3, output bad_index,
                  input ready);
  modport sink   (input valid, input parity_byte0, input parity_byte1,
                  input parity_byte2, input parity_byte3, input bad_index,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gf16_erasure_code_encoder.sv =====
// GF(16) erasure-code parity encoder.
// in_if carries one data byte and its data block index per transfer; bytes of
// one column arrive for blocks 0 .. k-1. Each nibble is multiplied by the
// coefficient of (data block, parity block) and XORed into up to four parity
// accumulators. The transfer of block k-1 produces one out_if transfer with
// the column's parity bytes and clears the accumulators. An index not below k
// produces one transfer with bad_index set and zero parity, and leaves the
// accumulators alone. Other indices produce no output.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the
// user must do so only while the block is idle (not enforced by the block);
// indices past the register list are ignored. Data passes an input register,
// then a result register; the GF products and XOR tree are combinational
// between the two registers. Throughput: one item per cycle unless the output
// stalls: with a result pending and out_if.ready low the result register holds;
// one more item may sit in the input register, after which in_if.ready drops.
// Reset clears coefficients to zero, k and m to one, accumulators to zero and
// both pipeline registers to empty.

`default_nettype none

module gf16_erasure_code_encoder import gfec_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  gfec_in_if.sink                 in_if,
  gfec_out_if.source              out_if
);

  logic [CoeffW-1:0] coeff_q [MaxParityBlocks];
  logic [KW-1:0]     dblk_q;
  logic [MW-1:0]     pblk_q;

  logic              s1_valid_q;
  logic [DataW-1:0]  s1_byte_q;
  logic [IdxW-1:0]   s1_idx_q;

  logic [DataW-1:0]  acc_q [MaxParityBlocks];
  logic [DataW-1:0]  acc_d [MaxParityBlocks];

  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  par_q [MaxParityBlocks];
  logic [DataW-1:0]  par_d [MaxParityBlocks];
  logic              bad_q;

  logic [KW-1:0]     k_eff;
  logic [MW-1:0]     m_eff;
  logic              bad, last, emits, out_free, adv;
  logic [DataW-1:0]  acc_upd [MaxParityBlocks];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MaxParityBlocks; j++) begin
        coeff_q[j] <= '0;
      end
      dblk_q <= KW'(1);
      pblk_q <= MW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCoeff0:       coeff_q[0] <= cfg_wdata_i[CoeffW-1:0];
        CfgCoeff1:       coeff_q[1] <= cfg_wdata_i[CoeffW-1:0];
        CfgCoeff2:       coeff_q[2] <= cfg_wdata_i[CoeffW-1:0];
        CfgCoeff3:       coeff_q[3] <= cfg_wdata_i[CoeffW-1:0];
        CfgDataBlocks:   dblk_q     <= cfg_wdata_i[KW-1:0];
        CfgParityBlocks: pblk_q     <= cfg_wdata_i[MW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free    = !out_valid_q || out_if.ready;
  assign adv         = s1_valid_q && out_free;
  assign in_if.ready = !s1_valid_q || adv;

  always_comb begin
    k_eff = (dblk_q > KW'(MaxDataBlocks)) ? KW'(MaxDataBlocks) : dblk_q;
    m_eff = (pblk_q > MW'(MaxParityBlocks)) ? MW'(MaxParityBlocks) : pblk_q;
    bad   = {1'b0, s1_idx_q} >= k_eff;
    last  = !bad && ({1'b0, s1_idx_q} == (k_eff - KW'(1)));
    emits = bad || last;
    for (int j = 0; j < MaxParityBlocks; j++) begin
      acc_upd[j] = acc_q[j];
      if (MW'(j) < m_eff) begin
        acc_upd[j] = acc_q[j] ^ gf16_mul_byte(s1_byte_q,
                                              coeff_q[j][{s1_idx_q, 2'b00} +: SymW]);
      end
      par_d[j] = (!bad && MW'(j) < m_eff) ? acc_upd[j] : '0;
      acc_d[j] = acc_q[j];
      if (adv && !bad) begin
        acc_d[j] = last ? '0 : acc_upd[j];
      end
    end
    out_valid_d = out_valid_q;
    if (adv && emits) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MaxParityBlocks; j++) begin
        acc_q[j] <= '0;
      end
    end else begin
      if (in_if.ready) begin
        s1_valid_q <= in_if.valid;
      end
      out_valid_q <= out_valid_d;
      for (int j = 0; j < MaxParityBlocks; j++) begin
        acc_q[j] <= acc_d[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_q <= in_if.data_byte;
      s1_idx_q  <= in_if.block_index;
    end
    if (adv && emits) begin
      for (int j = 0; j < MaxParityBlocks; j++) begin
        par_q[j] <= par_d[j];
      end
      bad_q <= bad;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.parity_byte0 = par_q[0];
  assign out_if.parity_byte1 = par_q[1];
  assign out_if.parity_byte2 = par_q[2];
  assign out_if.parity_byte3 = par_q[3];
  assign out_if.bad_index    = bad_q;

endmodule

`default_nettype wire

// ===== rtl/core/gfec_checker.sv =====
`default_nettype none

module gfec_checker import gfec_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [DataW-1:0] par0_i,
  input wire logic [DataW-1:0] par1_i,
  input wire logic [DataW-1:0] par2_i,
  input wire logic [DataW-1:0] par3_i,
  input wire logic             bad_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({par0_i, par1_i, par2_i, par3_i, bad_i}))
    else $error("output changed while stalled");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_i |-> (par0_i == '0) && (par1_i == '0) &&
      (par2_i == '0) && (par3_i == '0))
    else $error("bad index result carries parity");

  // an empty output side never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_xfer, 2))
    else $error("result without input transfer two cycles earlier");

endmodule

bind gf16_erasure_code_encoder gfec_checker u_gfec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .par0_i      (out_if.parity_byte0),
  .par1_i      (out_if.parity_byte1),
  .par2_i      (out_if.parity_byte2),
  .par3_i      (out_if.parity_byte3),
  .bad_i       (out_if.bad_index)
);

`default_nettype wire
